[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Each one samples on clk and is
// disabled while rst_n is low; both names must be in scope where used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, check holds too
`define ASSERT_SAME(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (check)) else $error(msg);

// Next-cycle implication: when cond holds, check holds in the next cycle
`define ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (check)) else $error(msg);

`endif

[hdl/sbfr_pkg.sv]
// ----------------------------------------------------------------------------
// sbfr_pkg
// Constants, status codes and the frame decode function of the start byte
// frame receiver.
// ----------------------------------------------------------------------------
package sbfr_pkg;

    // Frame layout
    localparam logic [7:0] START_BYTE = 8'hFA;
    localparam int         FRAME_LEN  = 6;
    localparam int         POS_W      = 3;
    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);

    // Command and subcommand codes
    localparam logic [7:0] CMD_GAME   = 8'h02;
    localparam logic [7:0] CMD_CELL   = 8'h04;
    localparam logic [7:0] SUB_START  = 8'h84;
    localparam logic [7:0] SUB_BLUE   = 8'h81;
    localparam logic [7:0] SUB_RED    = 8'h82;
    localparam logic [1:0] FIELD_BAD  = 2'h3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INVALID = 3'd0,
        ST_START   = 3'd1,
        ST_BLUE    = 3'd2,
        ST_RED     = 3'd3,
        ST_CELL    = 3'd4
    } frame_status_t;

    typedef struct packed {
        frame_status_t status;
        logic [1:0]    row;
        logic [1:0]    column;
        logic [1:0]    color;
    } frame_result_t;

    // Decode a complete frame. Byte 0 is always the start byte, so only
    // bytes 1..4 and the running XOR of bytes 0..5 are needed.
    function automatic frame_result_t decode_frame(
        input logic [7:0]  addr_lo,
        input logic [7:0]  addr_hi,
        input logic [7:0]  cmd,
        input logic [7:0]  sub,
        input logic [7:0]  xor_sum,
        input logic [15:0] display_number
    );
        frame_result_t res;
        logic          hdr_ok;
        res.status = ST_INVALID;
        res.row    = 2'd0;
        res.column = 2'd0;
        res.color  = 2'd0;
        hdr_ok = (addr_lo == display_number[7:0]) &&
                 (addr_hi == display_number[15:8]) &&
                 ((cmd == CMD_GAME) || (cmd == CMD_CELL)) &&
                 (xor_sum == 8'h00);
        if (hdr_ok) begin
            if (sub == SUB_START) begin
                res.status = ST_START;
            end else if (sub == SUB_BLUE) begin
                res.status = ST_BLUE;
            end else if (sub == SUB_RED) begin
                res.status = ST_RED;
            end else if ((sub[7:6] == 2'b00) && (sub[1:0] != FIELD_BAD) &&
                         (sub[3:2] != FIELD_BAD) && (sub[5:4] != FIELD_BAD)) begin
                res.status = ST_CELL;
                res.row    = sub[1:0];
                res.column = sub[3:2];
                res.color  = sub[5:4];
            end
        end
        return res;
    endfunction

endpackage

[hdl/start_byte_frame_receiver_decoder.sv]
// ----------------------------------------------------------------------------
// start_byte_frame_receiver_decoder
// Gathers received bytes into six-byte frames and decodes each frame.
// ----------------------------------------------------------------------------
// Takes one byte per clock while rx_stall is low. Byte 0xFA always opens
// a new frame and bytes outside a frame are dropped. The sixth byte of a
// frame yields one result transaction: header and XOR check, then the
// subcommand decode. A byte goes through an input register, and the decode
// of a final byte is registered in the output register that drives the
// output port. The output register frees the input side: a new byte is
// taken while a result waits, and rx_stall rises only when the decode stage
// holds a final byte and the pending result is not being taken.
// ----------------------------------------------------------------------------
module start_byte_frame_receiver_decoder
    import sbfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        display_number_wr_en,
    input  logic [15:0] display_number_wr_data,
    // byte input
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [2:0]  frame_status,
    output logic [1:0]  cell_row,
    output logic [1:0]  cell_column,
    output logic [1:0]  cell_color
);

    logic [15:0]      display_number_reg;
    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       byte1_reg, byte2_reg, byte3_reg, byte4_reg;
    logic             out_vld_reg;
    frame_result_t    out_reg;

    logic             is_start;
    logic             is_last;
    logic             out_free;
    logic             advance;
    frame_result_t    result;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            display_number_reg <= 16'd0;
        end else if (display_number_wr_en) begin
            display_number_reg <= display_number_wr_data;
        end
    end

    // Decode stage control
    assign is_start = (in_byte_reg == START_BYTE);
    assign is_last  = !is_start && in_frame_reg && (pos_reg >= LAST_POS);
    assign out_free = !out_vld_reg || !frame_stall;
    assign advance  = in_vld_reg && (!is_last || out_free);
    assign rx_stall = in_vld_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (rx_valid && !rx_stall) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (rx_valid && !rx_stall) begin
            in_byte_reg <= rx_byte;
        end
    end

    // Frame tracking
    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        if (is_start) begin
            in_frame_next = 1'b1;
            pos_next      = FIRST_POS;
            xor_next      = START_BYTE;
        end else if (is_last) begin
            in_frame_next = 1'b0;
            pos_next      = '0;
        end else if (in_frame_reg) begin
            pos_next = pos_reg + POS_W'(1);
            xor_next = xor_reg ^ in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
        end else if (advance) begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
        end
    end

    // Frame bytes, written by position
    always_ff @(posedge clk) begin
        if (advance) begin
            xor_reg <= xor_next;
            if (in_frame_reg && !is_start) begin
                case (pos_reg)
                    3'd1:    byte1_reg <= in_byte_reg;
                    3'd2:    byte2_reg <= in_byte_reg;
                    3'd3:    byte3_reg <= in_byte_reg;
                    3'd4:    byte4_reg <= in_byte_reg;
                    default: ;
                endcase
            end
        end
    end

    // Decode of a complete frame
    assign result = decode_frame(byte1_reg, byte2_reg, byte3_reg, byte4_reg,
                                 xor_reg ^ in_byte_reg, display_number_reg);

    // Result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (advance && is_last) begin
            out_vld_reg <= 1'b1;
        end else if (!frame_stall) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance && is_last) begin
            out_reg <= result;
        end
    end

    assign frame_valid  = out_vld_reg;
    assign frame_status = 3'(out_reg.status);
    assign cell_row     = out_reg.row;
    assign cell_column  = out_reg.column;
    assign cell_color   = out_reg.color;

endmodule

[hdl/sbfr_checker.sv]
// ----------------------------------------------------------------------------
// sbfr_checker
// Port-level checks of the start byte frame receiver, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbfr_checker
    import sbfr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       frame_valid,
    input logic       frame_stall,
    input logic [2:0] frame_status,
    input logic [1:0] cell_row,
    input logic [1:0] cell_column,
    input logic [1:0] cell_color
);

    // Only defined status codes leave the block
    `ASSERT_SAME(a_status_code, frame_valid, frame_status <= 3'(ST_CELL), "bad status code")

    // Cell fields are zero unless the result is a cell write
    `ASSERT_SAME(a_cell_zero, frame_valid && (frame_status != 3'(ST_CELL)), (cell_row == 2'd0) && (cell_column == 2'd0) && (cell_color == 2'd0), "cell fields not zero")

    // A cell write never carries the reserved field value
    `ASSERT_SAME(a_cell_range, frame_valid && (frame_status == 3'(ST_CELL)), (cell_row != FIELD_BAD) && (cell_column != FIELD_BAD) && (cell_color != FIELD_BAD), "cell field out of range")

    // A stalled result transaction holds its valid, status and row
    `ASSERT_NEXT(a_out_hold, frame_valid && frame_stall, frame_valid && $stable(frame_status) && $stable(cell_row), "stalled result changed")

endmodule

bind start_byte_frame_receiver_decoder sbfr_checker u_sbfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_status (frame_status),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .cell_color   (cell_color)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the start byte frame receiver. A short directed
// table covers the decode cases, then random frames (mostly well formed,
// some corrupted, truncated or padded with noise) run under several display
// numbers and idle patterns. Every accepted byte updates a local frame
// predictor; each result is checked in order against it or the table.
// ----------------------------------------------------------------------------
module tb;
    import sbfr_pkg::*;

    localparam int  DRAIN_CYCLES = 6;
    localparam int  LONG_HOLD    = 300;
    localparam int  PHASE_COUNT  = 5;
    localparam int  SEG_COUNT    = 4;
    localparam int  SEG_BYTES    = 44;
    localparam int  MAX_PRINTS   = 50;

    typedef enum logic [1:0] {
        ROW_NONE,
        ROW_TYPED,
        ROW_PREDICT
    } row_kind_t;

    typedef struct {
        logic [7:0]    rx;
        row_kind_t     kind;
        frame_result_t want;
    } dir_row_t;

    localparam frame_result_t RES_NONE    = '{ST_INVALID, 2'd0, 2'd0, 2'd0};
    localparam frame_result_t RES_START   = '{ST_START, 2'd0, 2'd0, 2'd0};
    localparam frame_result_t RES_RED     = '{ST_RED, 2'd0, 2'd0, 2'd0};
    localparam frame_result_t RES_CELL    = '{ST_CELL, 2'd2, 2'd2, 2'd2};

    logic        clk;
    logic        rst_n;
    logic        display_number_wr_en;
    logic [15:0] display_number_wr_data;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        frame_valid;
    logic        frame_stall;
    logic [2:0]  frame_status;
    logic [1:0]  cell_row;
    logic [1:0]  cell_column;
    logic [1:0]  cell_color;

    // predictor state
    logic [15:0] disp_cfg;
    bit          fr_open;
    logic [2:0]  fr_pos;
    logic [7:0]  fr_bytes [FRAME_LEN];

    frame_result_t pending_frames [$];
    int          error_count;
    int          byte_count;
    int          snd_idle_pct;
    int          rcv_stall_pct;
    int          hold_requests;
    int          hold_served;
    int          hold_left;

    // directed table: outside bytes, each subcommand, restarts, bad field
    dir_row_t directed_rows [37] = '{
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{8'hFF,      ROW_NONE,    RES_NONE},
        '{START_BYTE, ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{CMD_GAME,   ROW_NONE,    RES_NONE},
        '{SUB_START,  ROW_NONE,    RES_NONE},
        '{8'h7C,      ROW_TYPED,   RES_START},
        '{START_BYTE, ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{CMD_CELL,   ROW_NONE,    RES_NONE},
        '{SUB_BLUE,   ROW_NONE,    RES_NONE},
        '{START_BYTE, ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{CMD_CELL,   ROW_NONE,    RES_NONE},
        '{SUB_BLUE,   ROW_NONE,    RES_NONE},
        '{8'h7F,      ROW_PREDICT, RES_NONE},
        '{START_BYTE, ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{CMD_GAME,   ROW_NONE,    RES_NONE},
        '{SUB_RED,    ROW_NONE,    RES_NONE},
        '{8'h7A,      ROW_TYPED,   RES_RED},
        '{START_BYTE, ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{CMD_CELL,   ROW_NONE,    RES_NONE},
        '{8'h2A,      ROW_NONE,    RES_NONE},
        '{8'hD4,      ROW_TYPED,   RES_CELL},
        '{START_BYTE, ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{8'h00,      ROW_NONE,    RES_NONE},
        '{CMD_CELL,   ROW_NONE,    RES_NONE},
        '{8'h3F,      ROW_NONE,    RES_NONE},
        '{8'hC1,      ROW_TYPED,   RES_NONE}
    };

    start_byte_frame_receiver_decoder u_top (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .display_number_wr_en   (display_number_wr_en),
        .display_number_wr_data (display_number_wr_data),
        .rx_valid               (rx_valid),
        .rx_stall               (rx_stall),
        .rx_byte                (rx_byte),
        .frame_valid            (frame_valid),
        .frame_stall            (frame_stall),
        .frame_status           (frame_status),
        .cell_row               (cell_row),
        .cell_column            (cell_column),
        .cell_color             (cell_color)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Advance the frame predictor by one byte; returns 1 when a frame completes
    function automatic bit frame_byte_step(input logic [7:0] b, output frame_result_t res);
        logic [7:0] xsum;
        logic [7:0] sub;
        bit         hdr_ok;
        res = RES_NONE;
        if (b == START_BYTE)
        begin
            fr_bytes[0] = b;
            fr_pos      = 3'd1;
            fr_open     = 1'b1;
            return 1'b0;
        end
        if (!fr_open)
            return 1'b0;
        fr_bytes[fr_pos] = b;
        fr_pos = fr_pos + 3'd1;
        if (fr_pos < FRAME_LEN)
            return 1'b0;
        fr_open = 1'b0;
        fr_pos  = 3'd0;

        xsum = fr_bytes[0] ^ fr_bytes[1] ^ fr_bytes[2] ^ fr_bytes[3] ^ fr_bytes[4] ^
               fr_bytes[5];
        sub  = fr_bytes[4];
        hdr_ok = (fr_bytes[1] == disp_cfg[7:0]) && (fr_bytes[2] == disp_cfg[15:8]) &&
                 ((fr_bytes[3] == CMD_GAME) || (fr_bytes[3] == CMD_CELL)) &&
                 (xsum == 8'h00);
        if (hdr_ok)
        begin
            if (sub == SUB_START)
                res.status = ST_START;
            else if (sub == SUB_BLUE)
                res.status = ST_BLUE;
            else if (sub == SUB_RED)
                res.status = ST_RED;
            else if (sub[7:6] == 2'b00 && sub[1:0] != FIELD_BAD &&
                     sub[3:2] != FIELD_BAD && sub[5:4] != FIELD_BAD)
            begin
                res.status = ST_CELL;
                res.row    = sub[1:0];
                res.column = sub[3:2];
                res.color  = sub[5:4];
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Offer one byte, wait for the handshake, then update the prediction
    task automatic send_byte(input logic [7:0] b, input row_kind_t kind,
                             input frame_result_t want);
        frame_result_t res;
        bit            has_res;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall !== 1'b0)
            @(posedge clk);
        has_res = frame_byte_step(b, res);
        case (kind)
            ROW_PREDICT: if (has_res) pending_frames.push_back(res);
            ROW_TYPED:   pending_frames.push_back(want);
            default:     ;
        endcase
        byte_count++;
    endtask

    // Random frame: mostly well formed, some with a broken field, cut short or led by noise bytes
    task automatic send_random_frame();
        logic [7:0] fb [FRAME_LEN];
        int         shape;
        int         pick;
        int         len;
        shape = $urandom_range(99);
        pick  = $urandom_range(9);
        len   = FRAME_LEN;
        fb[0] = START_BYTE;
        fb[1] = disp_cfg[7:0];
        fb[2] = disp_cfg[15:8];
        fb[3] = $urandom_range(1) ? CMD_GAME : CMD_CELL;
        if (pick == 0)
            fb[4] = SUB_START;
        else if (pick == 1)
            fb[4] = SUB_BLUE;
        else if (pick == 2)
            fb[4] = SUB_RED;
        else if (pick < 7)
            fb[4] = {2'b00, 6'($urandom)};
        else
            fb[4] = 8'($urandom);

        if (shape >= 60 && shape < 70)
            fb[1 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        else if (shape >= 70 && shape < 78)
            fb[3] = 8'($urandom);
        fb[5] = fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4];
        if (shape >= 78 && shape < 86)
            fb[5] ^= 8'(1 << $urandom_range(7));
        else if (shape >= 86 && shape < 92)
            len = $urandom_range(1, FRAME_LEN - 1);
        else if (shape >= 92)
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), ROW_PREDICT, RES_NONE);

        for (int i = 0; i < len; i++)
            send_byte(fb[i], ROW_PREDICT, RES_NONE);
    endtask

    // Pause the sender until every expected result has arrived
    task automatic wait_results_done();
        rx_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_display(input logic [15:0] value);
        display_number_wr_en   <= 1'b1;
        display_number_wr_data <= value;
        @(posedge clk);
        display_number_wr_en   <= 1'b0;
        disp_cfg = value;
    endtask

    // Receiver stall: random, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            frame_stall <= 1'b1;
        end
        else
            frame_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && frame_valid === 1'b1 && frame_stall === 1'b0)
        begin
            if (pending_frames.size() == 0)
                report_mismatch($sformatf("unexpected result, status %0d", frame_status));
            else
            begin
                want = pending_frames.pop_front();
                if (frame_status !== want.status)
                    report_mismatch($sformatf("frame_status got %0d want %0d",
                                              frame_status, want.status));
                if (cell_row !== want.row)
                    report_mismatch($sformatf("cell_row got %0d want %0d",
                                              cell_row, want.row));
                if (cell_column !== want.column)
                    report_mismatch($sformatf("cell_column got %0d want %0d",
                                              cell_column, want.column));
                if (cell_color !== want.color)
                    report_mismatch($sformatf("cell_color got %0d want %0d",
                                              cell_color, want.color));
            end
        end
    end

    // Run limit
    initial
    begin
        #(64'd10_000_000);
        $display("simulation failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic [15:0] phase_cfg [PHASE_COUNT];
        int          snd_pct [SEG_COUNT];
        int          rcv_pct [SEG_COUNT];
        int          seg_end;
        phase_cfg = '{16'hFFFF, 16'($urandom), 16'h0000, 16'h8001, 16'($urandom)};
        snd_pct   = '{0, 81, 0, 14};
        rcv_pct   = '{0, 0, 81, 14};

        clk                    = 1'b0;
        rst_n                  = 1'b0;
        display_number_wr_en   = 1'b0;
        display_number_wr_data = 16'h0000;
        rx_valid               = 1'b0;
        rx_byte                = 8'h00;
        frame_stall            = 1'b0;
        disp_cfg               = 16'h0000;
        fr_open                = 1'b0;
        fr_pos                 = 3'd0;
        foreach (fr_bytes[i]) fr_bytes[i] = 8'h00;
        error_count   = 0;
        byte_count    = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases with the reset display number
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].want);
        wait_results_done();

        // random frames under each display number and idle pattern
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_display(phase_cfg[p]);
            for (int s = 0; s < SEG_COUNT; s++)
            begin
                snd_idle_pct  = snd_pct[s];
                rcv_stall_pct = rcv_pct[s];
                if (p == 1 && s == 0)
                    hold_requests++;
                seg_end = byte_count + SEG_BYTES;
                while (byte_count < seg_end)
                    send_random_frame();
            end
            wait_results_done();
        end

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[start_byte_frame_receiver_decoder.f]
+incdir+hdl
hdl/sbfr_pkg.sv
hdl/start_byte_frame_receiver_decoder.sv
hdl/sbfr_checker.sv
dv/tb.sv
